// ----- rtl/permutation_matrix_check_defines.svh -----
// assertion macros used by permutation_matrix_check.sv
`ifndef PERMUTATION_MATRIX_CHECK_DEFINES_SVH
`define PERMUTATION_MATRIX_CHECK_DEFINES_SVH

`ifndef SYNTHESIS

// checked property, ignored while reset is asserted
`define PMC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pmc assertion failed");

// checked property, also evaluated during reset
`define PMC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("pmc assertion failed");

`else

`define PMC_ASSERT(lbl, prop)
`define PMC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- rtl/pmc_pkg.sv -----
`default_nettype none

package pmc_pkg;

    // largest supported matrix dimension
    localparam int MAX_SIZE = 512;

    // widths derived from the maximum dimension
    localparam int ADDR_W = $clog2(MAX_SIZE);
    localparam int CNT_W  = $clog2(MAX_SIZE + 1);

    // fixed field widths
    localparam int SIZE_W = 10;
    localparam int ELEM_W = 32;
    localparam int SUM_W  = 50;

    // one column entry holds the zero count and the one count
    localparam int ENTRY_W = 2 * CNT_W;

endpackage

`default_nettype wire

// ----- rtl/pmc_ram.sv -----
`default_nettype none

module pmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/permutation_matrix_check.sv -----
`default_nettype none
`include "permutation_matrix_check_defines.svh"

// Streams an n-by-n matrix in row-major order, one element per input transfer, and
// after the last element of each matrix gives one result transfer: a flag that is set
// when every row and column has exactly one 1 and n-1 zeros, and the exact 50-bit sum
// of all elements. The block takes one element per clock cycle while it is not held
// off; the last element passes the write-back stage and then the result register. The
// rate is set by the column count memory, read when an element is taken and written
// back through its separate write port. The memory needs no clearing pass: the first row of
// each matrix writes every column entry fresh. Writing matrix_size (0 acts as 1, values
// above 512 act as 512) restarts the matrix and must only happen while the block is
// idle. Input is held off only while a result waits and a second one is ready behind it.
module permutation_matrix_check (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic        [pmc_pkg::SIZE_W-1:0]   i_cfg_wr_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [pmc_pkg::ELEM_W-1:0]   i_element,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic                                     o_is_permutation,
    output logic signed      [pmc_pkg::SUM_W-1:0]    o_total_sum
);

    localparam int AW = pmc_pkg::ADDR_W;
    localparam int CW = pmc_pkg::CNT_W;
    localparam int SW = pmc_pkg::SUM_W;
    localparam int EW = pmc_pkg::ELEM_W;

    // control carried from the accept stage to the write-back stage
    typedef struct packed {
        logic [AW-1:0] addr;
        logic          is_zero;
        logic          is_one;
        logic          first_row;
        logic          last_row;
        logic          last_item;
        logic          row_ok;
    } t_s1;

    logic [AW-1:0] r_last_idx;
    logic [AW-1:0] r_row;
    logic [AW-1:0] r_col;
    logic [CW-1:0] r_row_zero;
    logic [CW-1:0] r_row_one;
    logic [SW-1:0] r_sum;
    logic          r_all_ok;
    logic          r_s1_valid;
    t_s1           r_s1;
    logic [SW-1:0] r_s1_sum;
    logic          r_out_valid;
    logic          r_out_perm;
    logic [SW-1:0] r_out_sum;

    logic [AW-1:0] n_last_idx;
    logic [CW-1:0] n_row_zero;
    logic [CW-1:0] n_row_one;
    logic [SW-1:0] n_sum;
    logic          in_xfer;
    logic          s1_fire;
    logic          el_zero;
    logic          el_one;
    logic          last_col;
    logic          last_row;
    logic          rd_en;
    logic [pmc_pkg::ENTRY_W-1:0] rd_data;
    logic [pmc_pkg::ENTRY_W-1:0] wr_data;
    logic [CW-1:0] base_zero;
    logic [CW-1:0] base_one;
    logic [CW-1:0] col_zero;
    logic [CW-1:0] col_one;
    logic          col_ok;
    logic          item_ok;

    // effective size minus one, clamped to the supported range
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            n_last_idx = '0;
        end else if (i_cfg_wr_data > pmc_pkg::SIZE_W'(pmc_pkg::MAX_SIZE)) begin
            n_last_idx = AW'(pmc_pkg::MAX_SIZE - 1);
        end else begin
            n_last_idx = AW'(i_cfg_wr_data - pmc_pkg::SIZE_W'(1));
        end
    end

    // handshakes: the write-back stage only waits when its result has nowhere to go
    assign s1_fire    = r_s1_valid && (!r_s1.last_item || !r_out_valid || i_out_ready);
    assign o_in_ready = !(r_s1_valid && !s1_fire);
    assign in_xfer    = i_in_valid && o_in_ready;

    // element decode and row counters
    assign el_zero  = (i_element == '0);
    assign el_one   = (i_element == EW'(1));
    assign last_col = (r_col == r_last_idx);
    assign last_row = (r_row == r_last_idx);

    always_comb begin
        if (r_col == '0) begin
            n_row_zero = CW'(el_zero);
            n_row_one  = CW'(el_one);
        end else begin
            n_row_zero = r_row_zero + CW'(el_zero);
            n_row_one  = r_row_one + CW'(el_one);
        end
        n_sum = r_sum + {{(SW - EW){i_element[EW-1]}}, i_element};
    end

    // column counts are only read outside the first row
    assign rd_en = in_xfer && (r_row != '0);

    // read-modify-write of the column entry
    always_comb begin
        if (r_s1.first_row) begin
            base_zero = '0;
            base_one  = '0;
        end else begin
            base_zero = rd_data[2*CW-1:CW];
            base_one  = rd_data[CW-1:0];
        end
        col_zero = base_zero + CW'(r_s1.is_zero);
        col_one  = base_one + CW'(r_s1.is_one);
        col_ok   = !r_s1.last_row ||
                   ((col_zero == CW'(r_last_idx)) && (col_one == CW'(1)));
        item_ok  = r_all_ok && r_s1.row_ok && col_ok;
        wr_data  = {col_zero, col_one};
    end

    pmc_ram #(
        .WIDTH (pmc_pkg::ENTRY_W),
        .DEPTH (pmc_pkg::MAX_SIZE)
    ) u_col_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1.addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data)
    );

    // accept stage: positions, row counts and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_row_zero <= '0;
            r_row_one  <= '0;
            r_sum      <= '0;
        end else if (i_cfg_wr_en) begin
            r_last_idx <= n_last_idx;
            r_row      <= '0;
            r_col      <= '0;
            r_row_zero <= '0;
            r_row_one  <= '0;
            r_sum      <= '0;
        end else if (in_xfer) begin
            r_row_zero <= n_row_zero;
            r_row_one  <= n_row_one;
            if (last_col && last_row) begin
                r_row <= '0;
                r_col <= '0;
                r_sum <= '0;
            end else begin
                r_sum <= n_sum;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= r_row + AW'(1);
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
        end
    end

    // write-back stage payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.addr      <= r_col;
            r_s1.is_zero   <= el_zero;
            r_s1.is_one    <= el_one;
            r_s1.first_row <= (r_row == '0);
            r_s1.last_row  <= last_row;
            r_s1.last_item <= last_col && last_row;
            r_s1.row_ok    <= !last_col || ((n_row_zero == CW'(r_last_idx)) &&
                                            (n_row_one == CW'(1)));
            r_s1_sum       <= n_sum;
        end
    end

    // write-back stage control and running verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_all_ok   <= 1'b1;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_all_ok <= 1'b1;
            end else if (s1_fire) begin
                r_all_ok <= r_s1.last_item ? 1'b1 : item_ok;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1.last_item) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_fire && r_s1.last_item) begin
            r_out_perm <= item_ok;
            r_out_sum  <= r_s1_sum;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_is_permutation = r_out_perm;
    assign o_total_sum      = r_out_sum;

    // a column entry is never read in the cycle its update is written back
    `PMC_ASSERT(a_no_rmw_overlap, !(rd_en && s1_fire && (r_s1.addr == r_col)))
    // positions stay inside the matrix
    `PMC_ASSERT_ALWAYS(a_pos_range, !i_rst_n || ((r_col <= r_last_idx) && (r_row <= r_last_idx)))
    // a held write-back stage keeps its column and sum
    `PMC_ASSERT(a_s1_hold, (r_s1_valid && !s1_fire) |=> (r_s1_valid && $stable(r_s1.addr) && $stable(r_s1_sum)))
    // a new result only ever follows the last element of a matrix
    `PMC_ASSERT(a_out_source, (!r_out_valid || i_out_ready) ##1 r_out_valid |-> $past(r_s1_valid && r_s1.last_item))

endmodule

`default_nettype wire
